FILE: rtl/core/rtcc_pkg.sv
package rtcc_pkg;

  // Stream and register port widths.
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Bit positions of the packed fields (the same layout on both sides for the calendar).
  localparam int unsigned FracLo    = 34;
  localparam int unsigned ElapsedLo = 44;

  // Calendar limits.
  localparam logic [6:0] MaxSecond = 7'd59;
  localparam logic [6:0] MaxMinute = 7'd59;
  localparam logic [5:0] MaxHour   = 6'd23;
  localparam logic [4:0] MaxMonth  = 5'd12;
  localparam logic [7:0] LeapSkipA = 8'd100;
  localparam logic [7:0] LeapSkipB = 8'd200;

  // Sub-counter value at which a pending trim is applied.
  localparam logic [7:0] SubTrimPoint = 8'h7F;

  typedef enum logic {
    OpTick    = 1'b0,
    OpSetTime = 1'b1
  } opcode_e;

  typedef enum logic {
    RegMinuteTrim = 1'b0,
    RegHourTrim   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_t;

  typedef struct packed {
    logic [7:0] minute_trim;
    logic [7:0] hour_trim;
  } trim_t;

  typedef struct packed {
    logic minute_roll;
    logic hour_roll;
  } roll_t;

  localparam cal_t CalReset = '{
    year:   8'd0,
    month:  4'd1,
    day:    5'd1,
    hour:   5'd0,
    minute: 6'd0,
    second: 6'd0
  };

endpackage

FILE: rtl/core/rtc_calendar_counter.sv
// Channel   | Direction | Handshake              | Payload
// s_axis    | in        | tvalid / tready        | tuser: opcode; tdata: set-time fields
// m_axis    | out       | tvalid / tready        | tdata: calendar, fraction_ms, elapsed_ms
// apb       | in        | psel / penable / pready| trim registers at 0x0 and 0x4
//
// One item per cycle sustained while the output side is ready. An item waits in the input
// register and moves into the output register when it advances; the counter and calendar
// cascade updates in that step. Reset clears the valid flags, counters, calendar and trims.
// The input side is ready while the input register is empty or its item moves on, and
// it moves on when the result register is empty or its result leaves in the same cycle.
module rtc_calendar_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata from bit 0: set_year, set_month, set_day, set_hour, set_minute,
  // set_second, set_fraction, zero fill.
  input  logic [rtcc_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: opcode.
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata from bit 0: year, month, day, hour, minute, second, fraction_ms,
  // elapsed_ms, zero fill.
  output logic [rtcc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rtcc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rtcc_pkg::ApbDataW-1:0]  pwdata,
  output logic [rtcc_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import rtcc_pkg::*;

  trim_t trim;

  logic                  in_valid_q;
  opcode_e               in_op_q;
  logic [ElapsedLo-1:0]  in_data_q;
  logic                  out_valid_q;
  logic [OutDataW-1:0]   out_data_q;
  logic                  advance;

  logic [7:0]  sub_q, sub_d, sub_inc;
  logic [31:0] quarter_q, quarter_d;
  cal_t        cal_q, cal_d, cal_tick, cal_set;
  logic        pend_q, pend_d, is_hour_q, is_hour_d;
  logic        sub_wrap, sec_step;
  roll_t       roll;
  logic [9:0]  set_frac;
  logic [9:0]  fraction_ms;
  logic [31:0] elapsed_ms;

  rtcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .trim_o  (trim)
  );

  // Two-register pipeline: input register, then result register.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= opcode_e'(s_axis_tuser[0]);
      in_data_q <= s_axis_tdata[ElapsedLo-1:0];
    end
  end

  // Unpack the set-time fields.
  assign cal_set.year   = in_data_q[7:0];
  assign cal_set.month  = in_data_q[11:8];
  assign cal_set.day    = in_data_q[16:12];
  assign cal_set.hour   = in_data_q[21:17];
  assign cal_set.minute = in_data_q[27:22];
  assign cal_set.second = in_data_q[33:28];
  assign set_frac       = in_data_q[FracLo+9:FracLo];

  // Tick: the sub-counter wraps into the quarter count, every fourth quarter is a second.
  assign sub_inc  = sub_q + 8'd1;
  assign sub_wrap = (sub_q == 8'hFF);
  assign sec_step = sub_wrap && (quarter_q[1:0] == 2'b11);

  rtcc_calendar u_calendar (
    .cal_i      (cal_q),
    .sec_step_i (sec_step),
    .cal_o      (cal_tick),
    .roll_o     (roll)
  );

  // Next state of counters, calendar and pending trim.
  always_comb begin
    sub_d     = sub_q;
    quarter_d = quarter_q;
    cal_d     = cal_q;
    pend_d    = pend_q;
    is_hour_d = is_hour_q;
    unique case (in_op_q)
      OpTick: begin
        sub_d     = sub_inc;
        quarter_d = quarter_q + {31'd0, sub_wrap};
        cal_d     = cal_tick;
        if (roll.minute_roll) begin
          pend_d    = 1'b1;
          is_hour_d = roll.hour_roll;
        end
        // A pending trim lands when the sub-counter reaches its midpoint.
        if ((sub_inc == SubTrimPoint) && pend_d) begin
          sub_d  = sub_inc + (is_hour_d ? trim.hour_trim : trim.minute_trim);
          pend_d = 1'b0;
        end
      end
      OpSetTime: begin
        cal_d     = cal_set;
        quarter_d = {quarter_q[31:2], set_frac[9:8]};
        sub_d     = set_frac[7:0];
      end
      default: begin
        cal_d = cal_q;
      end
    endcase
  end

  rtcc_ms_scale u_ms_scale (
    .quarter_i     (quarter_d),
    .sub_i         (sub_d),
    .fraction_ms_o (fraction_ms),
    .elapsed_ms_o  (elapsed_ms)
  );

  // State registers advance once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q     <= '0;
      quarter_q <= '0;
      cal_q     <= CalReset;
      pend_q    <= 1'b0;
      is_hour_q <= 1'b0;
    end else if (advance) begin
      sub_q     <= sub_d;
      quarter_q <= quarter_d;
      cal_q     <= cal_d;
      pend_q    <= pend_d;
      is_hour_q <= is_hour_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {{(OutDataW-ElapsedLo-32){1'b0}}, elapsed_ms, fraction_ms,
                     cal_d.second, cal_d.minute, cal_d.hour, cal_d.day,
                     cal_d.month, cal_d.year};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/core/rtcc_regs.sv
module rtcc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rtcc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rtcc_pkg::ApbDataW-1:0]  pwdata,
  output logic [rtcc_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output rtcc_pkg::trim_t                trim_o
);
  import rtcc_pkg::*;

  trim_t    trim_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // Trim registers, written in the access phase of a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegMinuteTrim: trim_q.minute_trim <= pwdata[7:0];
        RegHourTrim:   trim_q.hour_trim   <= pwdata[7:0];
        default:       trim_q             <= trim_q;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_idx)
      RegMinuteTrim: prdata = {{(ApbDataW-8){1'b0}}, trim_q.minute_trim};
      RegHourTrim:   prdata = {{(ApbDataW-8){1'b0}}, trim_q.hour_trim};
      default:       prdata = '0;
    endcase
  end

  assign trim_o = trim_q;

endmodule

FILE: rtl/core/rtcc_calendar.sv
module rtcc_calendar (
  input  rtcc_pkg::cal_t  cal_i,
  input  logic            sec_step_i,
  output rtcc_pkg::cal_t  cal_o,
  output rtcc_pkg::roll_t roll_o
);
  import rtcc_pkg::*;

  // One-second advance of the calendar: second, minute, hour, day, month, year.
  always_comb begin : p_next
    logic       leap;
    logic [5:0] last_day;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_n;
    logic [4:0] mon_n;
    logic [7:0] year_n;

    leap = (cal_i.year[1:0] == 2'b00) && (cal_i.year != LeapSkipA) &&
           (cal_i.year != LeapSkipB);

    case (cal_i.month) inside
      4'd4, 4'd6, 4'd9, 4'd11: last_day = 6'd30;
      4'd2:                    last_day = leap ? 6'd29 : 6'd28;
      default:                 last_day = 6'd31;
    endcase

    sec_inc  = {1'b0, cal_i.second} + 7'd1;
    min_inc  = {1'b0, cal_i.minute} + 7'd1;
    hour_inc = {1'b0, cal_i.hour} + 6'd1;

    // Day step. A month past twelve wraps with a year carry even without a day carry.
    day_n  = {1'b0, cal_i.day} + 6'd1;
    mon_n  = {1'b0, cal_i.month};
    year_n = cal_i.year;
    if (day_n > last_day) begin
      day_n = 6'd1;
      mon_n = mon_n + 5'd1;
    end
    if (mon_n > MaxMonth) begin
      mon_n  = 5'd1;
      year_n = year_n + 8'd1;
    end

    cal_o  = cal_i;
    roll_o = '0;
    if (sec_step_i) begin
      if (sec_inc > MaxSecond) begin
        cal_o.second       = '0;
        roll_o.minute_roll = 1'b1;
        if (min_inc > MaxMinute) begin
          cal_o.minute     = '0;
          roll_o.hour_roll = 1'b1;
          if (hour_inc > MaxHour) begin
            cal_o.hour  = '0;
            cal_o.day   = day_n[4:0];
            cal_o.month = mon_n[3:0];
            cal_o.year  = year_n;
          end else begin
            cal_o.hour = hour_inc[4:0];
          end
        end else begin
          cal_o.minute = min_inc[5:0];
        end
      end else begin
        cal_o.second = sec_inc[5:0];
      end
    end
  end

endmodule

FILE: rtl/core/rtcc_ms_scale.sv
module rtcc_ms_scale (
  input  logic [31:0] quarter_i,
  input  logic [7:0]  sub_i,
  output logic [9:0]  fraction_ms_o,
  output logic [31:0] elapsed_ms_o
);

  logic [14:0] sub_prod;
  logic [7:0]  sub_ms;

  // A sub-counter step is 125/128 ms; a quarter second is 250 ms.
  assign sub_prod      = {7'd0, sub_i} * 15'd125;
  assign sub_ms        = sub_prod[14:7];
  assign fraction_ms_o = ({8'd0, quarter_i[1:0]} * 10'd250) + {2'd0, sub_ms};
  assign elapsed_ms_o  = (quarter_i * 32'd250) + {24'd0, sub_ms};

endmodule

FILE: rtl/core/rtcc_checker.sv
module rtcc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rtcc_pkg::OutDataW-1:0] m_axis_tdata
);
  import rtcc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // A ready sink never stalls the input side.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output side is ready");

  // Milliseconds within the second never reach a full second.
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[FracLo+9:FracLo] < 10'd1000))
    else $error("fraction_ms out of range");

  // After an input transfer the output valid is never unknown.
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$isunknown(m_axis_tvalid))
    else $error("output valid unknown after an input transfer");

endmodule

bind rtc_calendar_counter rtcc_checker u_rtcc_checker (.*);
